/* hw/rtl/ppw_pkg.sv */
// Shared types and constants for the packed-pixel to plane-write converter.
package ppw_pkg;

  localparam logic [15:0] ROW_STRIDE = 16'd80;
  localparam logic [15:0] VRAM_BASE  = 16'hC000;
  localparam logic [15:0] COLOR_PORT = 16'd53;
  localparam logic [4:0]  NO_COLOR   = 5'd16;

  // Write kinds on the result channel.
  localparam logic KIND_COLOR = 1'b0;
  localparam logic KIND_VRAM  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_START_COLUMN     = 3'd0;
  localparam logic [2:0] REG_START_ROW        = 3'd1;
  localparam logic [2:0] REG_WIDTH_BYTES      = 3'd2;
  localparam logic [2:0] REG_ROW_COUNT        = 3'd3;
  localparam logic [2:0] REG_TRANSPARENT_MODE = 3'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] pixel_pair;
    logic       image_start;
  } in_t;

  typedef struct packed {
    logic        write_kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [6:0] start_column;
    logic [7:0] start_row;
    logic [6:0] width_bytes;
    logic [7:0] row_count;
    logic       transparent_mode;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  data;
  } wr_t;

  // All writes caused by one input byte; last_idx is the count minus one.
  typedef struct packed {
    wr_t [3:0]  wr;
    logic [1:0] last_idx;
  } job_t;

endpackage

/* hw/rtl/ppw_front.sv */
// Front end: takes image bytes, tracks position and color, builds a job of writes.
module ppw_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ppw_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  input  ppw_pkg::in_t  in_data_i,
  output logic          in_stall_o,
  output logic          q_push_o,
  output ppw_pkg::job_t q_job_o,
  input  logic          q_full_i
);

  logic [15:0] dest_q, dest_d;
  logic [2:0]  bit_q, bit_d;
  logic [6:0]  cols_q, cols_d;
  logic [7:0]  rows_q, rows_d;
  logic [4:0]  last_q, last_d;
  logic [3:0]  key_q, key_d;

  logic [3:0]  hi, lo;
  logic        start;
  logic [15:0] start_addr;
  logic [15:0] eff_dest, dest_inc;
  logic [2:0]  eff_bit, bpm1;
  logic [6:0]  eff_cols, cols_dec;
  logic [7:0]  eff_rows;
  logic [4:0]  eff_last;
  logic [3:0]  eff_key;
  logic        active, skip, tmode, accept;
  logic [2:0]  n;
  ppw_pkg::wr_t [3:0] w;

  assign hi     = in_data_i.pixel_pair[7:4];
  assign lo     = in_data_i.pixel_pair[3:0];
  assign start  = in_data_i.image_start;
  assign tmode  = cfg_i.transparent_mode;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = q_full_i;

  assign start_addr = ppw_pkg::VRAM_BASE + 16'(cfg_i.start_row) * ppw_pkg::ROW_STRIDE
                      + 16'(cfg_i.start_column);

  assign eff_dest = start ? start_addr : dest_q;
  assign eff_bit  = start ? 3'd7 : bit_q;
  assign eff_cols = start ? cfg_i.width_bytes : cols_q;
  assign eff_rows = start ? ((cfg_i.width_bytes == 7'd0) ? 8'd0 : cfg_i.row_count) : rows_q;
  assign eff_last = start ? ppw_pkg::NO_COLOR : last_q;
  assign eff_key  = start ? hi : key_q;

  assign active = eff_rows != 8'd0;
  assign skip   = tmode ? (in_data_i.pixel_pair == {eff_key, eff_key})
                        : (in_data_i.pixel_pair == 8'd0);
  assign bpm1   = eff_bit - 3'd1;

  // Writes are packed into the job in issue order.
  always_comb begin
    w = '0;
    n = 3'd0;
    if (eff_last != {1'b0, hi}) begin
      w[n[1:0]] = '{kind: ppw_pkg::KIND_COLOR, address: ppw_pkg::COLOR_PORT,
                    data: {4'd0, hi}};
      n = n + 3'd1;
    end
    if (hi != lo) begin
      if (!(tmode && hi == eff_key)) begin
        w[n[1:0]] = '{kind: ppw_pkg::KIND_VRAM, address: eff_dest,
                      data: 8'd1 << eff_bit};
        n = n + 3'd1;
      end
      if (!(tmode && lo == eff_key)) begin
        w[n[1:0]] = '{kind: ppw_pkg::KIND_COLOR, address: ppw_pkg::COLOR_PORT,
                      data: {4'd0, lo}};
        n = n + 3'd1;
        w[n[1:0]] = '{kind: ppw_pkg::KIND_VRAM, address: eff_dest,
                      data: 8'd1 << bpm1};
        n = n + 3'd1;
      end
    end else if (!(tmode && hi == eff_key)) begin
      w[n[1:0]] = '{kind: ppw_pkg::KIND_VRAM, address: eff_dest,
                    data: 8'd3 << bpm1};
      n = n + 3'd1;
    end
  end

  assign q_push_o        = accept && active && !skip && (n != 3'd0);
  assign q_job_o.wr      = w;
  assign q_job_o.last_idx = 2'(n - 3'd1);

  assign dest_inc = eff_dest + 16'd1;
  assign cols_dec = eff_cols - 7'd1;

  always_comb begin
    dest_d = eff_dest;
    bit_d  = eff_bit;
    cols_d = eff_cols;
    rows_d = eff_rows;
    last_d = eff_last;
    key_d  = eff_key;
    if (active) begin
      if (!skip) begin
        last_d = {1'b0, lo};
      end
      if (eff_bit <= 3'd1) begin
        bit_d = 3'd7;
        if (cols_dec == 7'd0) begin
          rows_d = eff_rows - 8'd1;
          dest_d = dest_inc + ppw_pkg::ROW_STRIDE - {9'd0, cfg_i.width_bytes};
          cols_d = cfg_i.width_bytes;
        end else begin
          dest_d = dest_inc;
          cols_d = cols_dec;
        end
      end else begin
        bit_d = eff_bit - 3'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_q <= ppw_pkg::VRAM_BASE;
      bit_q  <= 3'd7;
      cols_q <= 7'd0;
      rows_q <= 8'd0;
      last_q <= ppw_pkg::NO_COLOR;
      key_q  <= 4'd0;
    end else if (accept) begin
      dest_q <= dest_d;
      bit_q  <= bit_d;
      cols_q <= cols_d;
      rows_q <= rows_d;
      last_q <= last_d;
      key_q  <= key_d;
    end
  end

endmodule

/* hw/rtl/ppw_queue.sv */
// Short job queue between the front end and the write sequencer.
module ppw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ppw_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ppw_pkg::job_t head_o
);

  ppw_pkg::job_t [ppw_pkg::QUEUE_DEPTH-1:0] mem_q;
  logic [ppw_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [ppw_pkg::QCNT_W-1:0] count_q;

  assign full_o  = count_q == ppw_pkg::QCNT_W'(ppw_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("job popped from an empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ppw_pkg::QCNT_W'(ppw_pkg::QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

/* hw/rtl/ppw_back.sv */
// Write sequencer: issues each job's writes, one per cycle unless stalled.
module ppw_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  ppw_pkg::job_t q_head_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  output ppw_pkg::out_t out_data_o,
  input  logic          out_stall_i
);

  ppw_pkg::job_t job_q;
  logic          job_valid_q;
  logic [1:0]    idx_q;
  logic          is_last, done;

  assign is_last = idx_q == job_q.last_idx;
  assign done    = job_valid_q && !out_stall_i && is_last;
  assign q_pop_o = q_valid_i && (!job_valid_q || done);

  assign out_valid_o              = job_valid_q;
  assign out_data_o.write_kind    = job_q.wr[idx_q].kind;
  assign out_data_o.write_address = job_q.wr[idx_q].address;
  assign out_data_o.write_data    = job_q.wr[idx_q].data;
  assign out_data_o.last          = is_last;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (q_pop_o) begin
      job_valid_q <= 1'b1;
      idx_q       <= 2'd0;
    end else if (done) begin
      job_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (job_valid_q && !out_stall_i) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

/* hw/rtl/packed_pixel_to_plane_writes_top.sv */
// Top level of the packed-pixel to plane-write converter with its register file.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  in      | input     | in_valid_i/in_stall_o | ppw_pkg::in_t
//  out     | output    | out_valid_o/out_stall_i | ppw_pkg::out_t
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A byte is taken while the job queue has room and becomes zero to four writes;
// the job goes through a queue entry and then the sequencer's job register before
// its first write leaves, and the rest follow at one transfer per cycle while the
// output is not stalled. The queue lets new bytes in while earlier writes issue.
// Reset is asynchronous and clears position, color state and the queue.
// A stall on the output backs up the queue and then stalls the input.
module packed_pixel_to_plane_writes_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  ppw_pkg::in_t  in_data_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output ppw_pkg::out_t out_data_o,
  input  logic          out_stall_i,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);

  ppw_pkg::cfg_t cfg_q;
  ppw_pkg::job_t push_job, head_job;
  logic          push, full, pop, q_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_column     <= 7'd0;
      cfg_q.start_row        <= 8'd0;
      cfg_q.width_bytes      <= 7'd1;
      cfg_q.row_count        <= 8'd1;
      cfg_q.transparent_mode <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ppw_pkg::REG_START_COLUMN:     cfg_q.start_column     <= cfg_data_i[6:0];
        ppw_pkg::REG_START_ROW:        cfg_q.start_row        <= cfg_data_i;
        ppw_pkg::REG_WIDTH_BYTES:      cfg_q.width_bytes      <= cfg_data_i[6:0];
        ppw_pkg::REG_ROW_COUNT:        cfg_q.row_count        <= cfg_data_i;
        ppw_pkg::REG_TRANSPARENT_MODE: cfg_q.transparent_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ppw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_push_o   (push),
    .q_job_o    (push_job),
    .q_full_i   (full)
  );

  ppw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  ppw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head_job),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
